@@ rtl/hscg_pkg.sv @@
package hscg_pkg;

	localparam int POWER_TABLE_DEPTH_DEF = 256;

	localparam int FRAC_W = 16;
	localparam int FACT_W = 17;
	localparam int CHAN_W = 24;
	localparam int RGB_W = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [FACT_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [FRAC_W-1:0] MIN_SPAN = 16'd7;
	localparam logic [FRAC_W-1:0] FULL_CODE = 16'd65535;

	localparam int DIV_STEPS = 17;
	localparam int DIV_PER_STAGE = 3;
	localparam int DIV_STAGES = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	localparam logic [14:0] SLOPE_GAIN = 15'd22938;

	localparam int NUM_RAMPS = 4;
	localparam int RECIP_W = 26;
	localparam int RECIP_SHIFT = 24;

	localparam logic [FACT_W-1:0] RAMP_START [NUM_RAMPS] =
		'{17'd0, 17'd16384, 17'd6554, 17'd45875};
	localparam logic [FRAC_W-1:0] RAMP_WIDTH [NUM_RAMPS] =
		'{16'd29491, 16'd36045, 16'd52429, 16'd19661};
	localparam logic [RECIP_W-1:0] RAMP_RECIP [NUM_RAMPS] = '{
		26'((64'd1 << 40) / 64'd29491),
		26'((64'd1 << 40) / 64'd36045),
		26'((64'd1 << 40) / 64'd52429),
		26'((64'd1 << 40) / 64'd19661)
	};

	localparam int RAMP_LOW = 0;
	localparam int RAMP_MID = 1;
	localparam int RAMP_HIGH = 2;
	localparam int RAMP_PEAK = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_WATER_LEVEL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WATER_DEEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WATER_SHALLOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MID = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK = 3'd6;

	localparam logic [RGB_W-1:0] RST_WATER_DEEP = 24'd865113;
	localparam logic [RGB_W-1:0] RST_WATER_SHALLOW = 24'd2056596;
	localparam logic [RGB_W-1:0] RST_LOW = 24'd3169328;
	localparam logic [RGB_W-1:0] RST_MID = 24'd6062146;
	localparam logic [RGB_W-1:0] RST_HIGH = 24'd7696476;
	localparam logic [RGB_W-1:0] RST_PEAK = 24'd15133682;

	typedef struct packed {
		logic water;
		logic [FRAC_W-1:0] slope;
	} side_t;

	typedef struct packed {
		logic water;
		logic [NUM_RAMPS-1:0][FACT_W-1:0] ramp;
		logic [FACT_W-1:0] smix;
		logic [FACT_W-1:0] wblend;
	} blend_t;

	typedef struct packed {
		logic [RGB_W-1:0] deep;
		logic [RGB_W-1:0] shallow;
		logic [RGB_W-1:0] low;
		logic [RGB_W-1:0] mid;
		logic [RGB_W-1:0] high;
		logic [RGB_W-1:0] peak;
	} colors_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bits;
		v = val;
		res = '0;
		bits = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bits > v) bits = bits >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bits != 0) begin
				if (v >= res + bits) begin
					v = v - (res + bits);
					res = (res >> 1) + bits;
				end else begin
					res = res >> 1;
				end
				bits = bits >> 2;
			end
		end
		return res;
	endfunction

	function automatic logic [FACT_W-1:0] pow_entry(input int idx, input int depth);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] e;
		x = (64'(idx) * 64'd65536) / 64'(depth - 1);
		s = isqrt64(x << 16);
		e = isqrt64(x * s);
		if (e > 64'd65536) e = 64'd65536;
		return FACT_W'(e);
	endfunction

	function automatic logic [CHAN_W-1:0] chan(input logic [RGB_W-1:0] packed_rgb,
		input int k);
		logic [7:0] c;
		c = packed_rgb[(16 - 8 * k) +: 8];
		return {c, 16'b0};
	endfunction

	function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic [FACT_W-1:0] f);
		logic signed [CHAN_W:0] d;
		logic signed [CHAN_W+FACT_W+1:0] p;
		logic signed [CHAN_W+FACT_W+2:0] s;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, f});
		s = $signed({(FACT_W + 3)'(0), a}) + (CHAN_W + FACT_W + 3)'(p >>> 16);
		return s[CHAN_W-1:0];
	endfunction

	function automatic logic [7:0] to8(input logic [CHAN_W-1:0] c);
		logic [CHAN_W:0] v;
		v = {1'b0, c} + 25'd32768;
		return (v[CHAN_W:16] > 9'd255) ? 8'd255 : v[23:16];
	endfunction

endpackage

@@ rtl/hscg_div.sv @@
module hscg_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [hscg_pkg::FRAC_W-1:0] num,
	input logic [hscg_pkg::FRAC_W-1:0] den,
	input hscg_pkg::side_t side_in,
	output logic out_valid,
	output logic [hscg_pkg::FACT_W-1:0] quot,
	output hscg_pkg::side_t side_out
);

	localparam int NST = hscg_pkg::DIV_STAGES;
	localparam int QW = hscg_pkg::FACT_W;

	logic v_s [NST];
	logic [QW-1:0] r_s [NST];
	logic [QW-1:0] q_s [NST];
	logic [hscg_pkg::FRAC_W-1:0] d_s [NST];
	hscg_pkg::side_t side_s [NST];

	for (genvar st = 0; st < NST; st++) begin : g_stage
		logic v_in;
		logic [QW-1:0] r_in;
		logic [QW-1:0] q_in;
		logic [hscg_pkg::FRAC_W-1:0] d_in;
		hscg_pkg::side_t side_prev;
		logic [QW-1:0] r_nx;
		logic [QW-1:0] q_nx;

		if (st == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = {1'b0, num};
			assign q_in = '0;
			assign d_in = den;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_in = v_s[st-1];
			assign r_in = r_s[st-1];
			assign q_in = q_s[st-1];
			assign d_in = d_s[st-1];
			assign side_prev = side_s[st-1];
		end

		always_comb begin
			r_nx = r_in;
			q_nx = q_in;
			for (int j = 0; j < hscg_pkg::DIV_PER_STAGE; j++) begin
				if (st * hscg_pkg::DIV_PER_STAGE + j < hscg_pkg::DIV_STEPS) begin
					if (st * hscg_pkg::DIV_PER_STAGE + j != 0) r_nx = {r_nx[QW-2:0], 1'b0};
					if (r_nx >= {1'b0, d_in}) begin
						r_nx = r_nx - {1'b0, d_in};
						q_nx = {q_nx[QW-2:0], 1'b1};
					end else begin
						q_nx = {q_nx[QW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[st] <= 1'b0;
			end else if (en) begin
				v_s[st] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[st] <= r_nx;
				q_s[st] <= q_nx;
				d_s[st] <= d_in;
				side_s[st] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign quot = q_s[NST-1];
	assign side_out = side_s[NST-1];

endmodule

@@ rtl/hscg_blend.sv @@
module hscg_blend #(
	parameter int POWER_TABLE_DEPTH = hscg_pkg::POWER_TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [hscg_pkg::FACT_W-1:0] t,
	input hscg_pkg::side_t side_in,
	output logic out_valid,
	output hscg_pkg::blend_t blend
);

	localparam int IDX_W = $clog2(POWER_TABLE_DEPTH);
	localparam int NR = hscg_pkg::NUM_RAMPS;
	localparam int FW = hscg_pkg::FACT_W;
	localparam int PW = FW + IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(POWER_TABLE_DEPTH - 1);

	logic [FW-1:0] rom [POWER_TABLE_DEPTH];

	for (genvar i = 0; i < POWER_TABLE_DEPTH; i++) begin : g_rom
		assign rom[i] = hscg_pkg::pow_entry(i, POWER_TABLE_DEPTH);
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic water_s1, water_s2, water_s3, water_s4;
	logic [IDX_W-1:0] idx_s1;
	logic [FW-1:0] wb_s2, wb_s3, wb_s4;
	logic [NR-1:0] zero_s1, zero_s2, zero_s3;
	logic [NR-1:0] full_s1, full_s2, full_s3;
	logic [NR-1:0][15:0] d_s1, d_s2, d_s3;
	logic [30:0] p_s1;
	logic [NR-1:0][41:0] rp_s2;
	logic [FW-1:0] smix_s2, smix_s3, smix_s4;
	logic [NR-1:0][15:0] q0_s3;
	logic [NR-1:0][31:0] qw_s3;
	logic [NR-1:0][FW-1:0] f_s4;

	logic [PW-1:0] iprod;
	logic [PW-17:0] idx_raw;
	logic [IDX_W-1:0] idx_nx;
	logic [FW-1:0] tc;
	logic [NR-1:0] zero_nx, full_nx;
	logic [NR-1:0][15:0] d_nx;
	logic [FW-1:0] dfull;
	logic [31:0] psum;
	logic [NR-1:0][15:0] q0_nx;
	logic [NR-1:0][FW-1:0] f_nx;
	logic [31:0] rem;

	always_comb begin
		iprod = PW'(t) * PW'(POWER_TABLE_DEPTH - 1) + PW'(32768);
		idx_raw = iprod[PW-1:16];
		idx_nx = (idx_raw > (PW - 16)'(LAST)) ? LAST : idx_raw[IDX_W-1:0];
		tc = (t > hscg_pkg::ONE_Q16) ? hscg_pkg::ONE_Q16 : t;
		for (int k = 0; k < NR; k++) begin
			zero_nx[k] = (tc <= hscg_pkg::RAMP_START[k]);
			dfull = tc - hscg_pkg::RAMP_START[k];
			full_nx[k] = (dfull >= {1'b0, hscg_pkg::RAMP_WIDTH[k]});
			d_nx[k] = dfull[15:0];
		end
	end

	always_comb begin
		psum = {1'b0, p_s1} + {17'b0, p_s1[30:16]} + 32'd1;
		for (int k = 0; k < NR; k++) begin
			q0_nx[k] = rp_s2[k][hscg_pkg::RECIP_SHIFT +: 16];
		end
	end

	always_comb begin
		rem = '0;
		for (int k = 0; k < NR; k++) begin
			rem = {d_s3[k], 16'b0} - qw_s3[k];
			if (zero_s3[k]) begin
				f_nx[k] = '0;
			end else if (full_s3[k]) begin
				f_nx[k] = hscg_pkg::ONE_Q16;
			end else if (rem >= {16'b0, hscg_pkg::RAMP_WIDTH[k]}) begin
				f_nx[k] = {1'b0, q0_s3[k]} + 17'd1;
			end else begin
				f_nx[k] = {1'b0, q0_s3[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			water_s1 <= side_in.water;
			idx_s1 <= idx_nx;
			zero_s1 <= zero_nx;
			full_s1 <= full_nx;
			d_s1 <= d_nx;
			p_s1 <= side_in.slope * hscg_pkg::SLOPE_GAIN;

			water_s2 <= water_s1;
			wb_s2 <= rom[idx_s1];
			zero_s2 <= zero_s1;
			full_s2 <= full_s1;
			d_s2 <= d_s1;
			smix_s2 <= psum[31:16] > 16'd22938 ? 17'd22938 : {1'b0, psum[31:16]};
			for (int k = 0; k < NR; k++) begin
				rp_s2[k] <= d_s1[k] * hscg_pkg::RAMP_RECIP[k];
			end

			water_s3 <= water_s2;
			wb_s3 <= wb_s2;
			zero_s3 <= zero_s2;
			full_s3 <= full_s2;
			d_s3 <= d_s2;
			smix_s3 <= smix_s2;
			q0_s3 <= q0_nx;
			for (int k = 0; k < NR; k++) begin
				qw_s3[k] <= q0_nx[k] * hscg_pkg::RAMP_WIDTH[k];
			end

			water_s4 <= water_s3;
			wb_s4 <= wb_s3;
			smix_s4 <= smix_s3;
			f_s4 <= f_nx;
		end
	end

	assign out_valid = v_s4;
	assign blend.water = water_s4;
	assign blend.ramp = f_s4;
	assign blend.smix = smix_s4;
	assign blend.wblend = wb_s4;

endmodule

@@ rtl/hscg_mix.sv @@
module hscg_mix (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input hscg_pkg::blend_t blend,
	input hscg_pkg::colors_t colors,
	output logic out_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	localparam int CW = hscg_pkg::CHAN_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic water_s1, water_s2, water_s3;
	logic [2:0][CW-1:0] a_s1, b_s1, g_s2, g_s3, g_s4;
	logic [hscg_pkg::FACT_W-1:0] hf_s1, pf_s1, pf_s2, sf_s1, sf_s2, sf_s3;
	logic [2:0][7:0] c8_s5;

	logic [2:0][CW-1:0] a_nx, b_nx, g2_nx, g3_nx, g4_nx;
	logic [2:0][7:0] c8_nx;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (blend.water) begin
				a_nx[k] = hscg_pkg::mix(hscg_pkg::chan(colors.deep, k),
					hscg_pkg::chan(colors.shallow, k), blend.wblend);
				b_nx[k] = a_nx[k];
			end else begin
				a_nx[k] = hscg_pkg::mix(hscg_pkg::chan(colors.low, k),
					hscg_pkg::chan(colors.mid, k), blend.ramp[hscg_pkg::RAMP_LOW]);
				b_nx[k] = hscg_pkg::mix(hscg_pkg::chan(colors.mid, k),
					hscg_pkg::chan(colors.high, k), blend.ramp[hscg_pkg::RAMP_MID]);
			end
			g2_nx[k] = water_s1 ? a_s1[k] : hscg_pkg::mix(a_s1[k], b_s1[k], hf_s1);
			g3_nx[k] = water_s2 ? g_s2[k] :
				hscg_pkg::mix(g_s2[k], hscg_pkg::chan(colors.peak, k), pf_s2);
			g4_nx[k] = water_s3 ? g_s3[k] :
				hscg_pkg::mix(g_s3[k], hscg_pkg::chan(colors.high, k), sf_s3);
			c8_nx[k] = hscg_pkg::to8(g_s4[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			water_s1 <= blend.water;
			a_s1 <= a_nx;
			b_s1 <= b_nx;
			hf_s1 <= blend.ramp[hscg_pkg::RAMP_HIGH];
			pf_s1 <= blend.ramp[hscg_pkg::RAMP_PEAK];
			sf_s1 <= blend.smix;

			water_s2 <= water_s1;
			g_s2 <= g2_nx;
			pf_s2 <= pf_s1;
			sf_s2 <= sf_s1;

			water_s3 <= water_s2;
			g_s3 <= g3_nx;
			sf_s3 <= sf_s2;

			g_s4 <= g4_nx;

			c8_s5 <= c8_nx;
		end
	end

	assign out_valid = v_s5;
	assign red = c8_s5[0];
	assign green = c8_s5[1];
	assign blue = c8_s5[2];

endmodule

@@ rtl/height_slope_color_gradient_top.sv @@
// Terrain color gradient: one height and slope sample in, one 8-bit RGB color out.
// The input channel (in_valid, in_ready, height, slope) and the output channel
// (out_valid, out_ready, red, green, blue) each move one transaction per cycle
// unless a stall holds them. The item passes 15 register stages, the first
// loaded at the accepting edge: 6 in the pipelined quotient unit (three
// quotient bits per stage, two in the last), 4 that form the blend factors
// (power table read, constant-width ramps by reciprocal multiply and correction),
// and 5 of color mixing, the last of which is the output register.
// Throughput is one transaction per cycle while no stall holds the pipeline.
// The pipeline advances as a whole whenever the output register is empty or is
// being taken. When the receiver holds out_ready low with a result waiting,
// every stage holds and in_ready falls, so nothing is lost or repeated.
// Registers are written through cfg_we, cfg_index and cfg_data with no wait;
// indexes above six are ignored. Write them only while no transaction is in
// flight. Asynchronous reset empties the pipeline and loads the default water
// level of zero and the default palette.
module height_slope_color_gradient_top #(
	parameter int POWER_TABLE_DEPTH = hscg_pkg::POWER_TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] height,
	input logic [15:0] slope,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	input logic cfg_we,
	input logic [hscg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [hscg_pkg::RGB_W-1:0] cfg_data
);

	logic [15:0] water_level_q;
	hscg_pkg::colors_t colors_q;

	logic adv;
	logic water;
	logic [15:0] span;
	logic [15:0] num;
	logic [15:0] den;
	hscg_pkg::side_t side_in;
	logic div_valid;
	logic [hscg_pkg::FACT_W-1:0] div_q;
	hscg_pkg::side_t div_side;
	logic blend_valid;
	hscg_pkg::blend_t blend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_level_q <= '0;
			colors_q.deep <= hscg_pkg::RST_WATER_DEEP;
			colors_q.shallow <= hscg_pkg::RST_WATER_SHALLOW;
			colors_q.low <= hscg_pkg::RST_LOW;
			colors_q.mid <= hscg_pkg::RST_MID;
			colors_q.high <= hscg_pkg::RST_HIGH;
			colors_q.peak <= hscg_pkg::RST_PEAK;
		end else if (cfg_we) begin
			case (cfg_index)
				hscg_pkg::CFG_WATER_LEVEL: water_level_q <= cfg_data[15:0];
				hscg_pkg::CFG_WATER_DEEP: colors_q.deep <= cfg_data;
				hscg_pkg::CFG_WATER_SHALLOW: colors_q.shallow <= cfg_data;
				hscg_pkg::CFG_LOW: colors_q.low <= cfg_data;
				hscg_pkg::CFG_MID: colors_q.mid <= cfg_data;
				hscg_pkg::CFG_HIGH: colors_q.high <= cfg_data;
				hscg_pkg::CFG_PEAK: colors_q.peak <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_comb begin
		water = height < water_level_q;
		span = hscg_pkg::FULL_CODE - water_level_q;
		if (water) begin
			num = height;
			den = (water_level_q >= hscg_pkg::MIN_SPAN) ? water_level_q : hscg_pkg::FULL_CODE;
		end else begin
			num = height - water_level_q;
			den = (span >= hscg_pkg::MIN_SPAN) ? span : hscg_pkg::FULL_CODE;
		end
		side_in.water = water;
		side_in.slope = slope;
	end

	hscg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(in_valid),
		.num(num),
		.den(den),
		.side_in(side_in),
		.out_valid(div_valid),
		.quot(div_q),
		.side_out(div_side)
	);

	hscg_blend #(
		.POWER_TABLE_DEPTH(POWER_TABLE_DEPTH)
	) u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(div_valid),
		.t(div_q),
		.side_in(div_side),
		.out_valid(blend_valid),
		.blend(blend)
	);

	hscg_mix u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(blend_valid),
		.blend(blend),
		.colors(colors_q),
		.out_valid(out_valid),
		.red(red),
		.green(green),
		.blue(blue)
	);

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid |-> div_q <= hscg_pkg::ONE_Q16)
		else $error("quotient above one");

	a_water_quot: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid && div_side.water |-> div_q < hscg_pkg::ONE_Q16)
		else $error("water fraction reached one");

	a_slope_mix: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid |-> blend.smix <= 17'd22938 && blend.wblend <= hscg_pkg::ONE_Q16)
		else $error("blend factor out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && blend_valid |=> blend_valid && $stable(blend))
		else $error("blend stage moved during a stall");

endmodule
